// ===== hw/rtl/icbw_pkg.sv =====
// Shared types, constants and the row-base function for the column blit writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package icbw_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int ADDR_W = 16;
    localparam int BAND_W = 2;
    localparam int DATA_W = 8;

    localparam int MAX_RESULTS = 3;

    localparam int ROWS_PER_COLUMN_DEF = 35;
    localparam int BAND_COUNT_DEF      = 3;
    localparam int SCREEN_COLUMNS_DEF  = 40;

    localparam logic [COL_W-1:0] START_COLUMN_RST = 8'd39;
    localparam logic [COL_W-1:0] END_COLUMN_RST   = 8'd255;

    // Register index codes on the configuration port
    typedef enum logic [0:0] {
        REG_START_COLUMN = 1'b0,
        REG_END_COLUMN   = 1'b1
    } reg_index_t;

    // One classified source byte, front to back
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              onscreen;
        logic              done;
    } blit_item_t;

    // Interleaved hires base of screen line 72 + 40*band + row
    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row,
                                                   input logic [BAND_W-1:0] band);
        logic [7:0]        line;
        logic [ADDR_W-1:0] base;
        line = 8'd72 + 8'({band, 5'b0}) + 8'({band, 3'b0}) + 8'(row);
        base = 16'h2000
             + 16'({line[2:0], 10'b0})
             + 16'({line[5:3], 7'b0})
             + 16'({line[7:6], 5'b0})
             + 16'({line[7:6], 3'b0});
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/icbw_front.sv =====
// Front end: accepts source bytes, tracks column and row, classifies each byte.
// Depends on icbw_pkg.
`default_nettype none

module icbw_front #(
    parameter int ROWS_PER_COLUMN = icbw_pkg::ROWS_PER_COLUMN_DEF,
    parameter int SCREEN_COLUMNS  = icbw_pkg::SCREEN_COLUMNS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [icbw_pkg::DATA_W-1:0] src_byte,
    input  wire logic                       q_full,
    input  wire logic                       restart,
    input  wire logic [icbw_pkg::COL_W-1:0] start_column,
    input  wire logic [icbw_pkg::COL_W-1:0] end_column,
    output logic                            in_ready,
    output logic                            q_push,
    output icbw_pkg::blit_item_t            q_item
);
    import icbw_pkg::*;

    localparam logic [ROW_W:0] ROWS_LIM   = (ROW_W+1)'(ROWS_PER_COLUMN);
    localparam logic [COL_W-1:0] SCR_COLS = COL_W'(SCREEN_COLUMNS);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_end;
    logic [COL_W-1:0] col_dec;
    logic             blit_end;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    assign col_end  = ({1'b0, row_reg} + 1'b1) >= ROWS_LIM;
    assign col_dec  = col_reg - 1'b1;
    assign blit_end = col_end && (col_dec == end_column);

    always_comb
    begin
        q_item.data     = src_byte;
        q_item.row      = row_reg;
        q_item.col      = col_reg;
        q_item.onscreen = col_reg < SCR_COLS;
        q_item.done     = blit_end;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = start_column;
            row_next = '0;
        end
        else if (q_push)
        begin
            if (col_end)
            begin
                row_next = '0;
                col_next = blit_end ? start_column : col_dec;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= START_COLUMN_RST;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/icbw_queue.sv =====
// Two-entry queue of classified bytes between front and back end.
// Depends on icbw_pkg.
`default_nettype none

module icbw_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire icbw_pkg::blit_item_t push_item,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output icbw_pkg::blit_item_t head_item
);
    import icbw_pkg::*;

    blit_item_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/icbw_back.sv =====
// Back end: expands each queued byte into band writes, one per cycle unless the
// output register stalls; off-screen bytes give one non-write result. Depends on icbw_pkg.
`default_nettype none

module icbw_back #(
    parameter int BAND_COUNT = icbw_pkg::BAND_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        head_valid,
    input  wire icbw_pkg::blit_item_t        head_item,
    output logic                             pop,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic                             write_valid,
    output logic [icbw_pkg::ADDR_W-1:0]      write_addr,
    output logic [icbw_pkg::DATA_W-1:0]      write_data,
    output logic [icbw_pkg::BAND_W-1:0]      band_index,
    output logic                             last_of_item,
    output logic                             blit_done
);
    import icbw_pkg::*;

    localparam int NRES_HI = (BAND_COUNT > MAX_RESULTS) ? MAX_RESULTS : BAND_COUNT;
    localparam int NRES    = (NRES_HI < 1) ? 1 : NRES_HI;
    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NRES - 1);

    logic [BAND_W-1:0] band_reg, band_next;
    logic              out_valid_reg, out_valid_next;
    logic              wvalid_reg, wvalid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [BAND_W-1:0] bidx_reg, bidx_next;
    logic              last_reg, last_next;
    logic              done_reg, done_next;

    logic load;
    logic step;
    logic last_res;

    assign load     = !out_valid_reg || out_ready;
    assign step     = load && head_valid;
    assign last_res = !head_item.onscreen || (band_reg == LAST_BAND);
    assign pop      = step && last_res;

    always_comb
    begin
        band_next      = band_reg;
        out_valid_next = out_valid_reg;
        wvalid_next    = wvalid_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        bidx_next      = bidx_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            band_next      = last_res ? '0 : band_reg + 1'b1;
            wvalid_next    = head_item.onscreen;
            data_next      = head_item.data;
            last_next      = last_res;
            done_next      = last_res && head_item.done;
            if (head_item.onscreen)
            begin
                addr_next = row_base(head_item.row, band_reg) + ADDR_W'(head_item.col);
                bidx_next = band_reg;
            end
            else
            begin
                addr_next = '0;
                bidx_next = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wvalid_reg <= wvalid_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        bidx_reg   <= bidx_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = wvalid_reg;
    assign write_addr   = addr_reg;
    assign write_data   = data_reg;
    assign band_index   = bidx_reg;
    assign last_of_item = last_reg;
    assign blit_done    = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/interleaved_column_blit_writer_unit.sv =====
// Column blit writer top level: APB register file, front end, queue, back end.
// Depends on icbw_pkg, icbw_front, icbw_queue, icbw_back.
//
// Usage:
//   Source bytes enter on in_valid/in_ready with src_byte, column by column,
//   ROWS_PER_COLUMN bytes per column. Results leave on out_valid/out_ready.
//   A byte in an on-screen column gives one framebuffer write per band
//   (up to three); a byte in an off-screen column gives one result with
//   write_valid clear. last_of_item marks a byte's final result, blit_done
//   the final result of the blit.
//   A byte passes through the queue, and its results through the single output
//   register, one result per cycle while out_ready is high. A two-entry
//   queue lets the input keep accepting while the output stalls; when
//   out_ready is low the current result holds and input stops once the
//   queue fills.
//   Reset loads start_column 39, end_column 255, column 39, row 0, and empties
//   the queue. Writing start_column restarts the blit; write registers only
//   while the block is idle.
`default_nettype none

module interleaved_column_blit_writer_unit #(
    parameter int ROWS_PER_COLUMN = icbw_pkg::ROWS_PER_COLUMN_DEF,
    parameter int BAND_COUNT      = icbw_pkg::BAND_COUNT_DEF,
    parameter int SCREEN_COLUMNS  = icbw_pkg::SCREEN_COLUMNS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [icbw_pkg::DATA_W-1:0]  src_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              write_valid,
    output logic [icbw_pkg::ADDR_W-1:0]       write_addr,
    output logic [icbw_pkg::DATA_W-1:0]       write_data,
    output logic [icbw_pkg::BAND_W-1:0]       band_index,
    output logic                              last_of_item,
    output logic                              blit_done
);
    import icbw_pkg::*;

    logic [COL_W-1:0] start_col_reg, start_col_next;
    logic [COL_W-1:0] end_col_reg, end_col_next;
    logic             wr_en;
    reg_index_t       reg_sel;
    logic             restart;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       head_valid;
    blit_item_t push_item;
    blit_item_t head_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign restart = wr_en && (reg_sel == REG_START_COLUMN);

    always_comb
    begin
        start_col_next = start_col_reg;
        end_col_next   = end_col_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_START_COLUMN: start_col_next = pwdata[COL_W-1:0];
                REG_END_COLUMN:   end_col_next   = pwdata[COL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_START_COLUMN: prdata = 32'(start_col_reg);
            REG_END_COLUMN:   prdata = 32'(end_col_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg <= START_COLUMN_RST;
            end_col_reg   <= END_COLUMN_RST;
        end
        else
        begin
            start_col_reg <= start_col_next;
            end_col_reg   <= end_col_next;
        end
    end

    // Front reloads from this both on a restart and at the end of a blit
    icbw_front #(
        .ROWS_PER_COLUMN (ROWS_PER_COLUMN),
        .SCREEN_COLUMNS  (SCREEN_COLUMNS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .src_byte     (src_byte),
        .q_full       (q_full),
        .restart      (restart),
        .start_column (start_col_next),
        .end_column   (end_col_reg),
        .in_ready     (in_ready),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    icbw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    icbw_back #(
        .BAND_COUNT (BAND_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (q_pop),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .write_valid  (write_valid),
        .write_addr   (write_addr),
        .write_data   (write_data),
        .band_index   (band_index),
        .last_of_item (last_of_item),
        .blit_done    (blit_done)
    );

endmodule

`default_nettype wire

// ===== dv/interleaved_column_blit_writer_unit_tb.sv =====
// Self-checking testbench for the interleaved column blit writer.
// Depends on icbw_pkg and the interleaved_column_blit_writer_unit RTL only.
`timescale 1ns / 100ps

module interleaved_column_blit_writer_unit_tb;
    import icbw_pkg::*;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [BAND_W-1:0] band;
        logic              last;
        logic              done;
    } blit_write_t;

    typedef enum logic [0:0] {
        ROW_BYTE = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        reg_index_t        reg_sel;
        logic [7:0]        val;
        int unsigned       reps;
        bit                typed;
        logic              t_wr;
        logic [ADDR_W-1:0] t_addr;
        logic [BAND_W-1:0] t_band;
    } table_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] src_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;
    logic [BAND_W-1:0] band_index;
    logic              last_of_item;
    logic              blit_done;

    interleaved_column_blit_writer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_byte     (src_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_valid  (write_valid),
        .write_addr   (write_addr),
        .write_data   (write_data),
        .band_index   (band_index),
        .last_of_item (last_of_item),
        .blit_done    (blit_done)
    );

    always #5 clk = ~clk;

    // Shadow of the block's registers and position
    logic [COL_W-1:0] shadow_start = START_COLUMN_RST;
    logic [COL_W-1:0] shadow_end   = END_COLUMN_RST;
    logic [COL_W-1:0] shadow_col   = START_COLUMN_RST;
    logic [ROW_W-1:0] shadow_row   = '0;

    blit_write_t expected_writes[$];
    table_row_t  stim_rows[$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned src_pct[5] = '{0, 78, 0, 19, 0};
    int unsigned sink_pct[5] = '{0, 0, 78, 19, 0};

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned writes_checked = 0;
    int unsigned blits_seen = 0;
    int unsigned skipped_seen = 0;

    // Typed expectation for the first result of the next accepted byte
    bit                typed_armed = 1'b0;
    logic              typed_wr;
    logic [ADDR_W-1:0] typed_addr;
    logic [BAND_W-1:0] typed_band;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [ADDR_W-1:0] hires_line_base(input int r, input int band);
        int line;
        line = (72 + 40 * band + r) & 255;
        return ADDR_W'(32'h2000 + ((line % 8) << 10) + (((line / 8) % 8) << 7)
                       + (line / 64) * 32'h28);
    endfunction

    task automatic set_register(input reg_index_t r, input logic [7:0] v);
        if (r == REG_START_COLUMN) begin
            shadow_start = v;
            shadow_col   = v;
            shadow_row   = '0;
        end else begin
            shadow_end = v;
        end
    endtask

    task automatic predict_writes(input logic [DATA_W-1:0] b);
        blit_write_t      w;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] nxt;
        logic [ROW_W-1:0] rw;
        bit               fin;
        int               n;
        col = shadow_col;
        rw  = shadow_row;
        fin = 1'b0;
        if (int'(rw) + 1 >= ROWS_PER_COLUMN_DEF) begin
            nxt = col - 8'd1;
            shadow_row = '0;
            if (nxt == shadow_end) begin
                fin = 1'b1;
                shadow_col = shadow_start;
            end else begin
                shadow_col = nxt;
            end
        end else begin
            shadow_row = rw + 6'd1;
        end
        if (int'(col) < SCREEN_COLUMNS_DEF) begin
            n = (BAND_COUNT_DEF > MAX_RESULTS) ? MAX_RESULTS : BAND_COUNT_DEF;
            for (int k = 0; k < n; k++) begin
                w.wr   = 1'b1;
                w.addr = hires_line_base(int'(rw), k) + ADDR_W'(col);
                w.data = b;
                w.band = BAND_W'(k);
                w.last = (k == n - 1);
                w.done = (k == n - 1) && fin;
                expected_writes.push_back(w);
                if (k == 0 && typed_armed) begin
                    if (w.wr != typed_wr) report_mismatch("table write_valid", w.wr, typed_wr);
                    if (w.addr != typed_addr)
                        report_mismatch("table write_addr", w.addr, typed_addr);
                    if (w.band != typed_band)
                        report_mismatch("table band_index", w.band, typed_band);
                    typed_armed = 1'b0;
                end
            end
        end else begin
            w = '{wr: 1'b0, addr: '0, data: b, band: '0, last: 1'b1, done: fin};
            expected_writes.push_back(w);
            if (typed_armed) begin
                if (w.wr != typed_wr) report_mismatch("table write_valid", w.wr, typed_wr);
                if (w.addr != typed_addr) report_mismatch("table write_addr", w.addr, typed_addr);
                if (w.band != typed_band) report_mismatch("table band_index", w.band, typed_band);
                typed_armed = 1'b0;
            end
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin : monitor
        blit_write_t w;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("result with nothing expected, write_addr", write_addr, 0);
                end else begin
                    w = expected_writes.pop_front();
                    if (write_valid != w.wr) report_mismatch("write_valid", write_valid, w.wr);
                    if (write_addr != w.addr) report_mismatch("write_addr", write_addr, w.addr);
                    if (write_data != w.data) report_mismatch("write_data", write_data, w.data);
                    if (band_index != w.band) report_mismatch("band_index", band_index, w.band);
                    if (last_of_item != w.last)
                        report_mismatch("last_of_item", last_of_item, w.last);
                    if (blit_done != w.done) report_mismatch("blit_done", blit_done, w.done);
                    writes_checked++;
                    if (w.done) blits_seen++;
                    if (!w.wr) skipped_seen++;
                end
            end
            if (in_valid && in_ready) begin
                predict_writes(src_byte);
                bytes_sent++;
            end
        end
    end

    // Entered and left at a falling edge; valid stays up for the caller to reuse
    task automatic push_byte(input logic [DATA_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        src_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input reg_index_t r, input logic [7:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(r));
        pwdata  <= {24'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        set_register(r, v);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata != {24'b0, v}) report_mismatch("prdata", prdata, {24'b0, v});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void add_row(input row_kind_t kind, input reg_index_t r,
                                    input logic [7:0] val, input int unsigned reps,
                                    input bit typed, input logic t_wr,
                                    input logic [ADDR_W-1:0] t_addr);
        table_row_t tr;
        tr = '{kind: kind, reg_sel: r, val: val, reps: reps, typed: typed,
               t_wr: t_wr, t_addr: t_addr, t_band: '0};
        stim_rows.push_back(tr);
    endfunction

    initial
    begin : stimulus
        logic [7:0]  st;
        logic [7:0]  en;
        int unsigned len;
        int unsigned phase_bytes;
        bit          paused;

        // Directed rows: reset position, byte extremes, off-screen skip, blit end and
        // restart, start register rewrite mid-column, end register changed mid-blit
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h00, 1, 1, 1'b1, 16'h20CF);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'hFF, 1, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h55, 1, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'hAA, 1, 0, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_START_COLUMN, 8'd255, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h12, 1, 1, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_START_COLUMN, 8'd0, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h80, 35, 1, 1'b1, 16'h20A8);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h01, 1, 1, 1'b1, 16'h20A8);
        add_row(ROW_CFG,  REG_END_COLUMN, 8'd38, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_START_COLUMN, 8'd40, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h30, 70, 1, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_START_COLUMN, 8'd39, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h40, 10, 0, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_START_COLUMN, 8'd39, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'h07, 1, 1, 1'b1, 16'h20CF);
        add_row(ROW_CFG,  REG_END_COLUMN, 8'd37, 0, 0, 1'b0, 16'h0000);
        add_row(ROW_BYTE, REG_START_COLUMN, 8'hC0, 69, 0, 1'b0, 16'h0000);
        add_row(ROW_CFG,  REG_END_COLUMN, 8'd255, 0, 0, 1'b0, 16'h0000);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                drain_results();
                cfg_write(stim_rows[i].reg_sel, stim_rows[i].val);
            end else begin
                for (int unsigned j = 0; j < stim_rows[i].reps; j++) begin
                    if (j == 0 && stim_rows[i].typed) begin
                        typed_wr    = stim_rows[i].t_wr;
                        typed_addr  = stim_rows[i].t_addr;
                        typed_band  = stim_rows[i].t_band;
                        typed_armed = 1'b1;
                    end
                    push_byte(stim_rows[i].val + 8'(j));
                end
            end
        end

        // Random blits under each idling mix
        for (int p = 0; p < 5; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            phase_bytes    = 0;
            paused         = 1'b0;
            while (phase_bytes < 24) begin
                case ($urandom_range(9))
                    0: st = 8'd0;
                    1: st = 8'd255;
                    2: st = 8'($urandom_range(42, 255));
                    default: st = 8'($urandom_range(0, 41));
                endcase
                case ($urandom_range(9))
                    0: en = 8'd255;
                    1: en = 8'd0;
                    2: en = 8'($urandom_range(255));
                    default: en = st - 8'($urandom_range(1, 3));
                endcase
                drain_results();
                cfg_write(REG_END_COLUMN, en);
                cfg_write(REG_START_COLUMN, st);
                len = $urandom_range(8, 36);
                for (int unsigned j = 0; j < len; j++) begin
                    if (!paused && j == len / 2) begin
                        drain_results();
                        paused = 1'b1;
                    end
                    push_byte(8'($urandom_range(255)));
                    phase_bytes++;
                end
            end
        end

        // Start equal to end: the blit carries on past the first column
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        drain_results();
        cfg_write(REG_END_COLUMN, 8'd200);
        cfg_write(REG_START_COLUMN, 8'd200);
        for (int unsigned j = 0; j < ROWS_PER_COLUMN_DEF + 5; j++)
            push_byte(8'($urandom_range(255)));

        drain_results();
        repeat (10) @(negedge clk);
        if (expected_writes.size() != 0)
            report_mismatch("results left over", expected_writes.size(), 0);

        $display("Sent %0d source bytes, checked %0d results (%0d off-screen skips)",
                 bytes_sent, writes_checked, skipped_seen);
        $display("Completed %0d blits across five idling mixes and a start-equals-end blit",
                 blits_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
